FILE: src/brie_pkg.sv
// ----------------------------------------------------------------------------
// brie_pkg
// shared constants and types of the bit run interval extender
// ----------------------------------------------------------------------------
package brie_pkg;

	// word memory geometry
	localparam int WORD_BITS  = 64;
	localparam int WORD_COUNT = 4096;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int MEM_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	// field widths
	localparam int POS_W      = 19;
	localparam int ADDR_W     = POS_W - BIT_W;
	localparam int IDX_W      = 12;
	localparam int DATA_W     = 64;
	localparam int CMD_W      = 2;
	localparam int IN_TDATA_W = ((IDX_W + DATA_W + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd2;

	// zero search request: direction and bit offset inside the word
	typedef struct packed {
		logic             left;
		logic [BIT_W-1:0] off;
	} zf_req_t;

	// zero search answer: offset of the run boundary in position order
	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} zf_rsp_t;

endpackage

FILE: src/brie_zero_find.sv
// ----------------------------------------------------------------------------
// brie_zero_find
// priority encoder locating the end of a run of ones within one memory word
// ----------------------------------------------------------------------------
module brie_zero_find (
	input  logic [brie_pkg::WORD_BITS-1:0] word,
	input  brie_pkg::zf_req_t              req,
	output brie_pkg::zf_rsp_t              rsp
);

	logic [brie_pkg::WORD_BITS-1:0] zero_pos;

	// position i of the word sits at bit WORD_BITS-1-i
	always_comb begin
		for (int i = 0; i < brie_pkg::WORD_BITS; i++) begin
			zero_pos[i] = ~word[brie_pkg::WORD_BITS-1-i];
		end
	end

	// left: last zero at or below the offset; right: first zero at or above it
	always_comb begin
		rsp = '0;
		if (req.left) begin
			for (int i = 0; i < brie_pkg::WORD_BITS; i++) begin
				if (zero_pos[i] && (i <= int'(req.off))) begin
					rsp.found = 1'b1;
					rsp.idx   = brie_pkg::BIT_W'(i);
				end
			end
		end else begin
			for (int i = brie_pkg::WORD_BITS - 1; i >= 0; i--) begin
				if (zero_pos[i] && (i >= int'(req.off))) begin
					rsp.found = 1'b1;
					rsp.idx   = brie_pkg::BIT_W'(i);
				end
			end
		end
	end

endmodule

FILE: src/bit_run_interval_extender_unit.sv
// ----------------------------------------------------------------------------
// bit_run_interval_extender_unit: bit run boundary scan over a word memory
// a query runs through ST_SCAN, one word read per scan step, and ST_RESULT to the output register
// a new input word is taken only from idle, once the last result has left ST_RESULT
// trivial queries (left at 0, right at or past the length) skip ST_SCAN; loads stay in ST_IDLE
// reset: async active low, clears control and length; memory is not cleared
// ----------------------------------------------------------------------------
//
// The bit array lives in a WORD_COUNT x WORD_BITS synchronous memory with one
// write port (loads) and one read port (queries, one word per cycle).
// A query walks the memory a word at a time: an extend-left walks toward
// position zero while words are all ones below the boundary, an extend-right
// walks upward while words are all ones and the length is not reached.
// Inside a word a priority encoder finds the first zero in walk direction.
// Loads and queries never overlap in the memory since a query only starts
// from idle, so a load is always visible to the next query's first read.
// Word addresses past the memory read as all zeros.
// The output register lets the next word in while a result waits on m_tready.

module bit_run_interval_extender_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: sequence_length
	input  logic                               cfg_wr_en,
	input  logic [brie_pkg::POS_W-1:0]         cfg_wr_data,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// word_index [11:0], word_data [75:12], position [94:76], zero pad
	input  logic [brie_pkg::IN_TDATA_W-1:0]    s_tdata,
	// command [1:0]
	input  logic [brie_pkg::CMD_W-1:0]         s_tuser,
	// result words
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// boundary [18:0], zero pad
	output logic [brie_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	// state codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	localparam int PAD_W = brie_pkg::OUT_TDATA_W - brie_pkg::POS_W;

	// input field split
	logic [brie_pkg::IDX_W-1:0]    in_idx;
	logic [brie_pkg::DATA_W-1:0]   in_data;
	logic [brie_pkg::POS_W-1:0]    in_pos;
	logic [brie_pkg::POS_W-1:0]    in_pos_m1;

	// control state
	logic [1:0]                    state_q;
	logic [brie_pkg::POS_W-1:0]    seq_q;
	logic                          m_tvalid_q;

	// walk state
	logic                          left_q;
	logic [brie_pkg::ADDR_W-1:0]   addr_q;
	logic [brie_pkg::BIT_W-1:0]    off_q;
	logic                          oor_q;
	logic [brie_pkg::POS_W-1:0]    res_q;
	logic [brie_pkg::POS_W-1:0]    out_q;

	// word memory
	logic [brie_pkg::WORD_BITS-1:0] mem [brie_pkg::WORD_COUNT];
	logic [brie_pkg::WORD_BITS-1:0] rd_data_s1;

	// read issue and scan decision
	logic                          accept;
	logic                          load_we;
	logic                          out_load;
	logic                          rd_en;
	logic [brie_pkg::ADDR_W-1:0]   rd_addr;
	logic [brie_pkg::BIT_W-1:0]    rd_off;
	logic                          rd_oor;
	logic                          scan_done;
	logic [brie_pkg::POS_W-1:0]    scan_res;
	logic [brie_pkg::POS_W-1:0]    base_pos;
	logic [brie_pkg::POS_W:0]      next_base;
	logic [brie_pkg::POS_W-1:0]    hit_pos;
	logic [brie_pkg::WORD_BITS-1:0] scan_word;
	brie_pkg::zf_req_t             zf_req;
	brie_pkg::zf_rsp_t             zf_rsp;

	assign in_idx    = s_tdata[brie_pkg::IDX_W-1:0];
	assign in_data   = s_tdata[brie_pkg::IDX_W +: brie_pkg::DATA_W];
	assign in_pos    = s_tdata[brie_pkg::IDX_W + brie_pkg::DATA_W +: brie_pkg::POS_W];
	assign in_pos_m1 = in_pos - brie_pkg::POS_W'(1);

	// a new word is taken only from idle; results park in res_q until the output register is free
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_we  = accept && (s_tuser == brie_pkg::CMD_LOAD);

	// parked result moves to the output register once that is free
	assign out_load = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_q};

	// current word: positions base_pos .. base_pos + WORD_BITS - 1
	assign base_pos  = {addr_q, {brie_pkg::BIT_W{1'b0}}};
	assign next_base = {1'b0, base_pos} + (brie_pkg::POS_W + 1)'(brie_pkg::WORD_BITS);
	assign scan_word = oor_q ? '0 : rd_data_s1;
	assign hit_pos   = base_pos + brie_pkg::POS_W'(zf_rsp.idx);

	assign zf_req.left = left_q;
	assign zf_req.off  = off_q;

	brie_zero_find u_zero_find (
		.word (scan_word),
		.req  (zf_req),
		.rsp  (zf_rsp)
	);

	// read address selection and end of walk detection
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = addr_q;
		rd_off    = off_q;
		scan_done = 1'b0;
		scan_res  = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == brie_pkg::CMD_LEFT && in_pos != '0) begin
						// start one below the boundary
						rd_en   = 1'b1;
						rd_addr = in_pos_m1[brie_pkg::POS_W-1:brie_pkg::BIT_W];
						rd_off  = in_pos_m1[brie_pkg::BIT_W-1:0];
					end else if (s_tuser == brie_pkg::CMD_RIGHT && in_pos < seq_q) begin
						rd_en   = 1'b1;
						rd_addr = in_pos[brie_pkg::POS_W-1:brie_pkg::BIT_W];
						rd_off  = in_pos[brie_pkg::BIT_W-1:0];
					end
				end
			end
			ST_SCAN: begin
				if (zf_rsp.found) begin
					scan_done = 1'b1;
					if (left_q) begin
						scan_res = hit_pos + brie_pkg::POS_W'(1);
					end else begin
						scan_res = (hit_pos < seq_q) ? hit_pos : seq_q;
					end
				end else if (left_q) begin
					// run reaches position zero
					if (addr_q == '0) begin
						scan_done = 1'b1;
						scan_res  = '0;
					end else begin
						rd_en   = 1'b1;
						rd_addr = addr_q - brie_pkg::ADDR_W'(1);
						rd_off  = '1;
					end
				end else begin
					// run reaches the sequence length
					if (next_base >= {1'b0, seq_q}) begin
						scan_done = 1'b1;
						scan_res  = seq_q;
					end else begin
						rd_en   = 1'b1;
						rd_addr = addr_q + brie_pkg::ADDR_W'(1);
						rd_off  = '0;
					end
				end
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	assign rd_oor = ({1'b0, rd_addr} >= (brie_pkg::ADDR_W + 1)'(brie_pkg::WORD_COUNT));

	// memory: one write port for loads, one registered read port for the walk
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem[in_idx[brie_pkg::MEM_AW-1:0]] <= in_data[brie_pkg::WORD_BITS-1:0];
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr[brie_pkg::MEM_AW-1:0]];
		end
	end

	// control: sequencer, length register, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seq_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				seq_q <= cfg_wr_data;
			end
			// a new result replaces one taken in the same cycle
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == brie_pkg::CMD_LEFT || s_tuser == brie_pkg::CMD_RIGHT) begin
							state_q <= rd_en ? ST_SCAN : ST_RESULT;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_q <= rd_addr;
			off_q  <= rd_off;
			oor_q  <= rd_oor;
		end
		if (accept) begin
			left_q <= (s_tuser == brie_pkg::CMD_LEFT);
			// trivial answers: left at zero, right at or past the length
			res_q  <= (s_tuser == brie_pkg::CMD_LEFT) ? '0 : seq_q;
		end else if (state_q == ST_SCAN && scan_done) begin
			res_q <= scan_res;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTH
	// a query never finishes in its accept cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (s_tuser == brie_pkg::CMD_LEFT || s_tuser == brie_pkg::CMD_RIGHT)
		|=> state_q != ST_IDLE)
		else $error("query returned to idle in its accept cycle");

	// a load leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		load_we |=> state_q == ST_IDLE)
		else $error("load left the sequencer busy");

	// the parked result is what gets presented
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && (!m_tvalid_q || m_tready)
		|=> m_tvalid && m_tdata[brie_pkg::POS_W-1:0] == $past(res_q))
		else $error("result register not transferred to output");

	// extend-right never passes the length
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && !left_q && !$past(cfg_wr_en) |-> res_q <= seq_q)
		else $error("extend-right result beyond sequence length");

	// a read is only issued when a word will be consumed next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> state_q == ST_SCAN)
		else $error("memory read issued without a scan to use it");
`endif

endmodule

FILE: bench/bit_run_interval_extender_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_run_interval_extender_unit_tb
// drives load words and extend-left / extend-right queries into the unit,
// keeps its own image of the bit memory and length register, predicts each
// run boundary and checks the result words in order under random idling
// ----------------------------------------------------------------------------
module bit_run_interval_extender_unit_tb;

	localparam int CLK_PERIOD    = 20;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_POS       = 262144;
	localparam int HOT_WORDS     = 32;
	// command value the unit takes and drops
	localparam logic [brie_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [brie_pkg::POS_W-1:0]       cfg_wr_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [brie_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic [brie_pkg::CMD_W-1:0]       s_tuser;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [brie_pkg::OUT_TDATA_W-1:0] m_tdata;

	// image of the bit memory and of the length register
	bit [brie_pkg::WORD_BITS-1:0] bit_image [brie_pkg::WORD_COUNT];
	bit                           word_written [brie_pkg::WORD_COUNT];
	int                           cur_length;

	// boundaries still owed by the unit, oldest first
	logic [brie_pkg::POS_W-1:0] pending_positions [$];
	logic [brie_pkg::POS_W-1:0] expected_position;

	int     fail_count     = 0;
	int     accepted_items = 0;
	int     stall_left     = 0;
	longint cycle_count    = 0;
	bit     tx_gaps_on     = 1'b0;
	bit     rx_stalls_on   = 1'b0;

	bit_run_interval_extender_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// boundary prediction
	// ------------------------------------------------------------------------

	// walk toward position zero while the bits below k are ones;
	// hole reports the first never-loaded word the walk would read
	function automatic int scan_left(input int k, output int hole);
		int p, r, t, a;
		bit [brie_pkg::WORD_BITS-1:0] w;
		hole = -1;
		if (k == 0)
			return 0;
		p = k - 1;
		while (p >= 0) begin
			a = p / brie_pkg::WORD_BITS;
			r = p % brie_pkg::WORD_BITS;
			if (a < brie_pkg::WORD_COUNT && !word_written[a]) begin
				hole = a;
				return 0;
			end
			w = (a < brie_pkg::WORD_COUNT) ? bit_image[a] : '0;
			// position p sits at bit WORD_BITS-1-r, lower positions above it
			for (t = 0; t <= r; t++)
				if (!w[brie_pkg::WORD_BITS-1-r+t])
					return p - t + 1;
			p -= r + 1;
		end
		return 0;
	endfunction

	// first zero at or after l, never past the length
	function automatic int scan_right(input int l, output int hole);
		int p, r, c, a;
		bit [brie_pkg::WORD_BITS-1:0] w;
		hole = -1;
		p = l;
		while (p < cur_length) begin
			a = p / brie_pkg::WORD_BITS;
			r = p % brie_pkg::WORD_BITS;
			if (a < brie_pkg::WORD_COUNT && !word_written[a]) begin
				hole = a;
				return 0;
			end
			w = (a < brie_pkg::WORD_COUNT) ? bit_image[a] : '0;
			for (c = 0; c < brie_pkg::WORD_BITS - r; c++)
				if (!w[brie_pkg::WORD_BITS-1-r-c])
					return (p + c < cur_length) ? p + c : cur_length;
			p += brie_pkg::WORD_BITS - r;
		end
		return cur_length;
	endfunction

	function automatic int predict_boundary(input logic [brie_pkg::CMD_W-1:0] cmd,
			input int pos, output int hole);
		hole = -1;
		if (cmd == brie_pkg::CMD_LEFT)
			return scan_left(pos, hole);
		if (cmd == brie_pkg::CMD_RIGHT)
			return scan_right(pos, hole);
		return 0;
	endfunction

	// ------------------------------------------------------------------------
	// random choices
	// ------------------------------------------------------------------------

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// word contents biased toward long runs of ones
	function automatic logic [brie_pkg::DATA_W-1:0] make_pattern();
		logic [brie_pkg::DATA_W-1:0] ones;
		ones = '1;
		case ($urandom_range(6))
			0, 1: return ones;
			2: return '0;
			3: return ones ^ (64'd1 << $urandom_range(63));
			4: return ones >> $urandom_range(63);
			5: return ones << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// most traffic in a few words at each end of memory so runs build up
	function automatic int pick_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return $urandom_range(HOT_WORDS - 1);
		if (roll < 90)
			return $urandom_range(brie_pkg::WORD_COUNT - 1, brie_pkg::WORD_COUNT - HOT_WORDS);
		return $urandom_range(brie_pkg::WORD_COUNT - 1);
	endfunction

	function automatic int pick_position();
		int roll, p;
		roll = $urandom_range(99);
		if (roll < 85)
			return pick_word() * brie_pkg::WORD_BITS + $urandom_range(brie_pkg::WORD_BITS);
		if (roll < 95) begin
			// around the length
			p = cur_length + $urandom_range(130) - 65;
			return (p < 0) ? 0 : (p > MAX_POS) ? MAX_POS : p;
		end
		return ($urandom_range(1) == 0) ? 0 : MAX_POS;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// one input word; the image and the owed boundaries follow at acceptance
	task automatic send_word(input logic [brie_pkg::CMD_W-1:0] cmd, input int idx,
			input logic [brie_pkg::DATA_W-1:0] data, input int pos);
		int gap, hole, boundary;
		logic [brie_pkg::IDX_W-1:0] idx_bits;
		logic [brie_pkg::POS_W-1:0] pos_bits;
		idx_bits = idx[brie_pkg::IDX_W-1:0];
		pos_bits = pos[brie_pkg::POS_W-1:0];
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= brie_pkg::IN_TDATA_W'({pos_bits, data, idx_bits});
		do @(posedge clk); while (!s_tready);
		case (cmd)
			brie_pkg::CMD_LOAD: begin
				bit_image[idx_bits]    = data;
				word_written[idx_bits] = 1'b1;
			end
			brie_pkg::CMD_LEFT, brie_pkg::CMD_RIGHT: begin
				boundary = predict_boundary(cmd, pos, hole);
				pending_positions.push_back(boundary[brie_pkg::POS_W-1:0]);
			end
			default: ;
		endcase
		if (cmd != CMD_NONE)
			accepted_items++;
	endtask

	// a query; any word its walk would read is loaded first
	task automatic run_query(input logic [brie_pkg::CMD_W-1:0] cmd, input int pos);
		int hole;
		void'(predict_boundary(cmd, pos, hole));
		while (hole >= 0) begin
			send_word(brie_pkg::CMD_LOAD, hole, make_pattern(), $urandom_range(MAX_POS));
			void'(predict_boundary(cmd, pos, hole));
		end
		send_word(cmd, $urandom_range(brie_pkg::WORD_COUNT - 1), {$urandom, $urandom}, pos);
	endtask

	// stop sending and let every owed result come back
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(input int len);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len[brie_pkg::POS_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		cur_length = len;
	endtask

	// ------------------------------------------------------------------------
	// result checker and receiver stalls
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_positions.size() == 0) begin
				$display("%0t: result word with nothing owed, expected none, actual %0d",
					$time, m_tdata[brie_pkg::POS_W-1:0]);
				fail_count++;
			end else begin
				expected_position = pending_positions.pop_front();
				if (m_tdata[brie_pkg::POS_W-1:0] !== expected_position) begin
					$display("%0t: boundary mismatch, expected %0d, actual %0d",
						$time, expected_position, m_tdata[brie_pkg::POS_W-1:0]);
					fail_count++;
				end
			end
		end
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (rx_stalls_on)
				stall_left <= pick_gap();
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// length still at its reset value of zero
	task automatic test_reset_length();
		cur_length = 0;
		run_query(brie_pkg::CMD_RIGHT, 0);
		run_query(brie_pkg::CMD_RIGHT, 1000);
		run_query(brie_pkg::CMD_RIGHT, MAX_POS);
		run_query(brie_pkg::CMD_LEFT, 0);
		settle_idle();
	endtask

	// hand-placed runs: zero start, word crossings, top of memory, clamping
	task automatic test_directed_boundaries();
		write_length(MAX_POS);
		send_word(brie_pkg::CMD_LOAD, 0, '1, MAX_POS);
		send_word(brie_pkg::CMD_LOAD, 1, 64'hFFFF_0000_0000_0000, 0);
		send_word(brie_pkg::CMD_LOAD, 2, '0, 0);
		send_word(brie_pkg::CMD_LOAD, 3, 64'h7FFF_FFFF_FFFF_FFFE, 0);
		send_word(brie_pkg::CMD_LOAD, brie_pkg::WORD_COUNT - 2, 64'h0000_0000_0000_0001, 0);
		send_word(brie_pkg::CMD_LOAD, brie_pkg::WORD_COUNT - 1, '1, 0);
		// left at zero, runs that reach position zero and runs that stop inside a word
		run_query(brie_pkg::CMD_LEFT, 0);
		run_query(brie_pkg::CMD_LEFT, 64);
		run_query(brie_pkg::CMD_LEFT, 80);
		run_query(brie_pkg::CMD_LEFT, 81);
		run_query(brie_pkg::CMD_LEFT, 194);
		// run across the top two words
		run_query(brie_pkg::CMD_LEFT, MAX_POS);
		// right walks, at the length and up to it
		run_query(brie_pkg::CMD_RIGHT, 0);
		run_query(brie_pkg::CMD_RIGHT, 128);
		run_query(brie_pkg::CMD_RIGHT, 193);
		run_query(brie_pkg::CMD_RIGHT, MAX_POS - 44);
		run_query(brie_pkg::CMD_RIGHT, MAX_POS);
		// dropped command with every field bit set
		send_word(CMD_NONE, brie_pkg::WORD_COUNT - 1, '1, 19'h7FFFF);
		settle_idle();
		// length inside a run of ones clamps the answer
		write_length(70);
		run_query(brie_pkg::CMD_RIGHT, 0);
		run_query(brie_pkg::CMD_RIGHT, 69);
		run_query(brie_pkg::CMD_RIGHT, 70);
		settle_idle();
	endtask

	// random loads and queries under one length setting
	task automatic test_random_scan(input int len, input int items, input bit gaps,
			input bit stalls);
		int goal, roll;
		write_length(len);
		tx_gaps_on   = gaps;
		rx_stalls_on = stalls;
		goal = accepted_items + items;
		while (accepted_items < goal) begin
			roll = $urandom_range(99);
			if (roll < 25)
				send_word(brie_pkg::CMD_LOAD, pick_word(), make_pattern(),
					$urandom_range(MAX_POS));
			else if (roll < 60)
				run_query(brie_pkg::CMD_LEFT, pick_position());
			else if (roll < 95)
				run_query(brie_pkg::CMD_RIGHT, pick_position());
			else
				send_word(CMD_NONE, $urandom_range(brie_pkg::WORD_COUNT - 1),
					{$urandom, $urandom}, $urandom_range(MAX_POS));
		end
		settle_idle();
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= brie_pkg::CMD_LOAD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_length();
		test_directed_boundaries();
		// back-to-back words first, then idling on one or both sides
		test_random_scan(MAX_POS, 250, 1'b0, 1'b0);
		test_random_scan(MAX_POS, 250, 1'b1, 1'b1);
		test_random_scan($urandom_range(MAX_POS), 200, 1'b1, 1'b1);
		test_random_scan($urandom_range(3000, 1), 200, 1'b1, 1'b0);
		test_random_scan(brie_pkg::WORD_BITS * $urandom_range(40, 1), 200, 1'b0, 1'b1);
		test_random_scan(0, 60, 1'b1, 1'b1);
		test_random_scan(1, 60, 1'b1, 1'b1);

		settle_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
